FILE: sv/par2_recovery_accumulate_macros.svh
// Assertion macros shared by the recovery accumulator modules.
// Included by every file that carries concurrent assertions; no dependencies.
`ifndef PAR2_RECOVERY_ACCUMULATE_MACROS_SVH
`define PAR2_RECOVERY_ACCUMULATE_MACROS_SVH
`ifndef SYNTHESIS
`define P2RA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
      else $error(msg);
`define P2RA_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);
`else
`define P2RA_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define P2RA_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif
`endif

FILE: sv/p2ra_pkg.sv
// Package for the recovery accumulator: widths, store geometry, shared types
// and the GF(2^16) multiply helpers. No dependencies.
package p2ra_pkg;

   localparam int unsigned WORD_W = 16;
   localparam int unsigned BLOCK_W = 15;
   localparam int unsigned EXPO_W = 15;
   localparam int unsigned SLOT_W = 2;
   localparam int unsigned IDX_W = 12;
   localparam int unsigned LOG_W = 16;
   localparam int unsigned PROD_W = LOG_W + EXPO_W;
   localparam int unsigned CLMUL_W = 2 * WORD_W - 1;

   localparam int unsigned SLICE_WORDS = 4096;
   localparam int unsigned NUM_OUTPUTS = 4;
   localparam int unsigned STORE_DEPTH = SLICE_WORDS * NUM_OUTPUTS;
   localparam int unsigned STORE_AW = $clog2(STORE_DEPTH);

   localparam int unsigned CLOG_DEPTH = 1 << BLOCK_W;
   localparam int unsigned ALOG_DEPTH = 1 << LOG_W;

   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);
   localparam int unsigned FIFO_CW = $clog2(FIFO_DEPTH + 1);

   localparam logic [WORD_W:0] GF_POLY = 17'h1100B;

   typedef struct packed {
      logic [WORD_W-1:0]   word;
      logic [LOG_W-1:0]    expo;
      logic [SLOT_W-1:0]   slot;
      logic [IDX_W-1:0]    idx;
      logic [STORE_AW-1:0] addr;
      logic                in_range;
      logic                overwrite;
   } item_type;

   typedef struct packed {
      logic                active;
      logic [LOG_W-1:0]    addr;
      logic [WORD_W-1:0]   alog_data;
      logic                clog_we;
      logic [BLOCK_W-1:0]  clog_addr;
      logic [LOG_W-1:0]    clog_data;
   } init_type;

   typedef logic [WORD_W-1:0] red_table_type [CLMUL_W-WORD_W];

   // Entry i holds x^(16+i) reduced by the field polynomial.
   function automatic red_table_type build_red_table();
      red_table_type t;
      logic [WORD_W:0] v;
      v = 17'h1;
      for (int i = 0; i < CLMUL_W; i++) begin
         if (i >= WORD_W) t[i-WORD_W] = v[WORD_W-1:0];
         v = {v[WORD_W-1:0], 1'b0};
         if (v[WORD_W]) v = v ^ GF_POLY;
      end
      return t;
   endfunction

   localparam red_table_type RED_TABLE = build_red_table();

   function automatic logic [CLMUL_W-1:0] gf_clmul(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
      logic [CLMUL_W-1:0] r;
      r = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (b[i]) r = r ^ (CLMUL_W'(a) << i);
      end
      return r;
   endfunction

   function automatic logic [WORD_W-1:0] gf_reduce(input logic [CLMUL_W-1:0] p);
      logic [WORD_W-1:0] r;
      r = p[WORD_W-1:0];
      for (int i = 0; i < CLMUL_W - WORD_W; i++) begin
         if (p[WORD_W+i]) r = r ^ RED_TABLE[i];
      end
      return r;
   endfunction

endpackage

FILE: sv/p2ra_init.sv
// Table build sequencer: after reset it sweeps every field exponent once,
// producing antilog entries, input constant logs and the store clear address.
// Depends on p2ra_pkg.
module p2ra_init import p2ra_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   output init_type init
);

   logic              active_ff, active_in;
   logic [LOG_W-1:0]  k_ff, k_in;
   logic [WORD_W-1:0] lfsr_ff, lfsr_in;
   logic [1:0]        r3_ff, r3_in;
   logic [2:0]        r5_ff, r5_in;
   logic [4:0]        r17_ff, r17_in;
   logic [8:0]        r257_ff, r257_in;
   logic [BLOCK_W-1:0] cnt_ff, cnt_in;
   logic              coprime;
   logic [WORD_W:0]   lfsr_shift;

   assign coprime = (r3_ff != '0) && (r5_ff != '0) && (r17_ff != '0) && (r257_ff != '0);
   assign lfsr_shift = {lfsr_ff, 1'b0};

   always_comb begin
      active_in = active_ff;
      k_in = k_ff;
      lfsr_in = lfsr_ff;
      r3_in = r3_ff;
      r5_in = r5_ff;
      r17_in = r17_ff;
      r257_in = r257_ff;
      cnt_in = cnt_ff;
      if (active_ff) begin
         k_in = k_ff + 1'b1;
         lfsr_in = lfsr_shift[WORD_W] ? lfsr_shift[WORD_W-1:0] ^ GF_POLY[WORD_W-1:0]
                                      : lfsr_shift[WORD_W-1:0];
         r3_in = (r3_ff == 2'd2) ? '0 : r3_ff + 1'b1;
         r5_in = (r5_ff == 3'd4) ? '0 : r5_ff + 1'b1;
         r17_in = (r17_ff == 5'd16) ? '0 : r17_ff + 1'b1;
         r257_in = (r257_ff == 9'd256) ? '0 : r257_ff + 1'b1;
         if (coprime) cnt_in = cnt_ff + 1'b1;
         if (k_ff == '1) active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b1;
         k_ff <= '0;
         lfsr_ff <= WORD_W'(1);
         r3_ff <= '0;
         r5_ff <= '0;
         r17_ff <= '0;
         r257_ff <= '0;
         cnt_ff <= '0;
      end else begin
         active_ff <= active_in;
         k_ff <= k_in;
         lfsr_ff <= lfsr_in;
         r3_ff <= r3_in;
         r5_ff <= r5_in;
         r17_ff <= r17_in;
         r257_ff <= r257_in;
         cnt_ff <= cnt_in;
      end
   end

   assign init.active = active_ff;
   assign init.addr = k_ff;
   assign init.alog_data = lfsr_ff;
   assign init.clog_we = active_ff && coprime;
   assign init.clog_addr = cnt_ff;
   assign init.clog_data = k_ff;

endmodule

FILE: sv/p2ra_front.sv
// Front end: accepts requests, classifies them, looks up the input constant
// log and forms the folded coefficient exponent. Depends on p2ra_pkg.
`include "par2_recovery_accumulate_macros.svh"
module p2ra_front import p2ra_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [WORD_W-1:0]   req_data_word,
   input  logic [BLOCK_W-1:0]  req_input_block_number,
   input  logic [EXPO_W-1:0]   req_recovery_exponent,
   input  logic [SLOT_W-1:0]   req_output_slot,
   input  logic [IDX_W-1:0]    req_word_index,
   input  logic                req_first_block,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  init_type            init,
   input  logic [FIFO_CW-1:0]  fifo_count,
   output logic                push,
   output item_type            push_item
);

   logic               acc_existing_ff, acc_existing_in;
   logic               accept;
   logic               s1_valid_ff;
   item_type           s1_ff, s1_in;
   logic               s2_valid_ff;
   item_type           s2_ff;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [LOG_W-1:0]   clog_mem [CLOG_DEPTH];
   logic [LOG_W-1:0]   clog_rd_ff;
   logic [FIFO_CW:0]   occupancy;
   logic [LOG_W:0]     fold1, fold2;

   // Every request in flight ahead of the queue must still find a free entry.
   assign occupancy = (FIFO_CW + 1)'(fifo_count) + (FIFO_CW + 1)'(s1_valid_ff)
                    + (FIFO_CW + 1)'(s2_valid_ff);
   assign busy = init.active || (occupancy > (FIFO_CW + 1)'(FIFO_DEPTH - 1));
   assign accept = start && !busy;

   assign acc_existing_in = csr_wr_en ? csr_wr_data : acc_existing_ff;

   always_comb begin
      s1_in.word = req_data_word;
      s1_in.expo = LOG_W'(req_recovery_exponent);
      s1_in.slot = req_output_slot;
      s1_in.idx = req_word_index;
      s1_in.addr = STORE_AW'(32'(req_output_slot) * SLICE_WORDS + 32'(req_word_index));
      s1_in.in_range = (32'(req_output_slot) < NUM_OUTPUTS)
                    && (32'(req_word_index) < SLICE_WORDS);
      s1_in.overwrite = req_first_block && !acc_existing_ff;
   end

   assign prod_in = PROD_W'(clog_rd_ff) * PROD_W'(s1_ff.expo[EXPO_W-1:0]);

   always_ff @(posedge clock) begin
      if (init.clog_we) clog_mem[init.clog_addr] <= init.clog_data;
      clog_rd_ff <= clog_mem[req_input_block_number];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_existing_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         acc_existing_ff <= acc_existing_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_ff <= s1_in;
      s2_ff <= s1_ff;
      prod_ff <= prod_in;
   end

   // Two folds of the high half into the low half reduce modulo 65535.
   assign fold1 = (LOG_W + 1)'(prod_ff[PROD_W-1:LOG_W]) + (LOG_W + 1)'(prod_ff[LOG_W-1:0]);
   assign fold2 = (LOG_W + 1)'(fold1[LOG_W]) + (LOG_W + 1)'(fold1[LOG_W-1:0]);

   assign push = s2_valid_ff;
   always_comb begin
      push_item = s2_ff;
      push_item.expo = fold2[LOG_W-1:0];
   end

   `P2RA_ASSERT_IMP(a_accept_reaches_queue, clock, reset, accept, ##2 push,
                    "accepted request did not reach the queue")
   `P2RA_ASSERT_NEVER(a_no_accept_during_build, clock, reset, accept && init.active,
                      "request accepted while tables were being built")

endmodule

FILE: sv/p2ra_fifo.sv
// Short queue between the front end and the back end.
// Depends on p2ra_pkg for the entry type and depth.
`include "par2_recovery_accumulate_macros.svh"
module p2ra_fifo import p2ra_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  item_type           push_item,
   input  logic               pop,
   output logic               head_valid,
   output item_type           head_item,
   output logic [FIFO_CW-1:0] count
);

   item_type             q_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CW-1:0]   count_ff, count_in;
   logic                 do_pop;

   assign do_pop = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == FIFO_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == FIFO_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) q_ff[wr_ptr_ff] <= push_item;
   end

   assign head_valid = (count_ff != '0);
   assign head_item = q_ff[rd_ptr_ff];
   assign count = count_ff;

   `P2RA_ASSERT_NEVER(a_no_overflow, clock, reset,
                      push && !do_pop && (32'(count_ff) == FIFO_DEPTH),
                      "queue written while full")

endmodule

FILE: sv/p2ra_back.sv
// Back end: antilog lookup, GF(2^16) multiply and the read-modify-write of
// the recovery store, with the response register. Depends on p2ra_pkg.
`include "par2_recovery_accumulate_macros.svh"
module p2ra_back import p2ra_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  init_type           init,
   input  logic               head_valid,
   input  item_type           head_item,
   output logic               pop,
   output logic               rsp_valid,
   output logic [WORD_W-1:0]  rsp_result_word,
   output logic [SLOT_W-1:0]  rsp_result_slot,
   output logic [IDX_W-1:0]   rsp_result_index
);

   logic [WORD_W-1:0]   alog_mem [ALOG_DEPTH];
   logic [WORD_W-1:0]   store_mem [STORE_DEPTH];
   logic [WORD_W-1:0]   alog_rd_ff;
   logic [WORD_W-1:0]   st_rd_ff;

   logic                b1_valid_ff;
   item_type            b1_ff;
   logic                b2_valid_ff;
   item_type            b2_ff;
   logic [CLMUL_W-1:0]  clprod_ff, clprod_in;

   logic                b3_valid_ff;
   logic                b3_wr_ff;
   logic [STORE_AW-1:0] b3_addr_ff;
   logic [WORD_W-1:0]   b3_word_ff, b3_word_in;
   logic [SLOT_W-1:0]   b3_slot_ff;
   logic [IDX_W-1:0]    b3_idx_ff;

   logic [WORD_W-1:0]   product;
   logic [WORD_W-1:0]   old_word;
   logic [WORD_W-1:0]   new_word;
   logic                forward;
   logic                st_we;
   logic [STORE_AW-1:0] st_waddr;
   logic [WORD_W-1:0]   st_wdata;

   assign pop = head_valid;

   assign clprod_in = gf_clmul(b1_ff.word, alog_rd_ff);

   // The store read for the next request misses the write made in the same
   // cycle, so that word is taken from the response register instead.
   assign forward = b3_valid_ff && b3_wr_ff && (b3_addr_ff == b2_ff.addr);
   assign product = gf_reduce(clprod_ff);
   assign old_word = forward ? b3_word_ff : st_rd_ff;
   assign new_word = b2_ff.overwrite ? product : (old_word ^ product);
   assign b3_word_in = b2_ff.in_range ? new_word : '0;

   always_comb begin
      if (init.active) begin
         st_we = (32'(init.addr) < STORE_DEPTH);
         st_waddr = STORE_AW'(init.addr);
         st_wdata = '0;
      end else begin
         st_we = b2_valid_ff && b2_ff.in_range;
         st_waddr = b2_ff.addr;
         st_wdata = new_word;
      end
   end

   always_ff @(posedge clock) begin
      if (init.active) alog_mem[init.addr] <= init.alog_data;
      alog_rd_ff <= alog_mem[head_item.expo];
   end

   always_ff @(posedge clock) begin
      if (st_we) store_mem[st_waddr] <= st_wdata;
      st_rd_ff <= store_mem[b1_ff.addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff <= 1'b0;
         b2_valid_ff <= 1'b0;
         b3_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff <= head_valid;
         b2_valid_ff <= b1_valid_ff;
         b3_valid_ff <= b2_valid_ff;
      end
      b1_ff <= head_item;
      b2_ff <= b1_ff;
      clprod_ff <= clprod_in;
      b3_wr_ff <= b2_ff.in_range;
      b3_addr_ff <= b2_ff.addr;
      b3_word_ff <= b3_word_in;
      b3_slot_ff <= b2_ff.slot;
      b3_idx_ff <= b2_ff.idx;
   end

   assign rsp_valid = b3_valid_ff;
   assign rsp_result_word = b3_word_ff;
   assign rsp_result_slot = b3_slot_ff;
   assign rsp_result_index = b3_idx_ff;

   `P2RA_ASSERT_IMP(a_pop_gives_response, clock, reset, pop, ##3 rsp_valid,
                    "request taken from the queue produced no response")
   `P2RA_ASSERT_IMP(a_no_update_during_build, clock, reset, init.active, !b2_valid_ff,
                    "store update collided with the clearing pass")

endmodule

FILE: sv/par2_recovery_accumulate.sv
// Top level of the recovery accumulator: table builder, front end, queue
// and back end. Depends on p2ra_pkg and the four p2ra_* modules.
//
// One request is accepted per clock while busy is low, and each request
// produces exactly one response, shown for a single cycle with rsp_valid; the
// receiver cannot stall, so the back end never waits and busy stays low in
// normal operation. The rate is set by the single read-modify-write port of
// the recovery store, which takes one word per cycle; back-to-back updates of
// the same word are forwarded from the response register. After reset busy
// stays high while the antilog and input constant log tables are built by one
// sweep over all field exponents, and the recovery store is cleared as the
// sweep passes the exponents below STORE_DEPTH. The accumulate register is
// written through csr_wr_en and csr_wr_data and may be written at any time
// while no request is in flight.
module par2_recovery_accumulate import p2ra_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [WORD_W-1:0]   req_data_word,
   input  logic [BLOCK_W-1:0]  req_input_block_number,
   input  logic [EXPO_W-1:0]   req_recovery_exponent,
   input  logic [SLOT_W-1:0]   req_output_slot,
   input  logic [IDX_W-1:0]    req_word_index,
   input  logic                req_first_block,
   output logic                rsp_valid,
   output logic [WORD_W-1:0]   rsp_result_word,
   output logic [SLOT_W-1:0]   rsp_result_slot,
   output logic [IDX_W-1:0]    rsp_result_index,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data
);

   init_type           init;
   logic               push;
   item_type           push_item;
   logic               pop;
   logic               head_valid;
   item_type           head_item;
   logic [FIFO_CW-1:0] fifo_count;

   p2ra_init u_init (
      .clock (clock),
      .reset (reset),
      .init  (init)
   );

   p2ra_front u_front (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_data_word          (req_data_word),
      .req_input_block_number (req_input_block_number),
      .req_recovery_exponent  (req_recovery_exponent),
      .req_output_slot        (req_output_slot),
      .req_word_index         (req_word_index),
      .req_first_block        (req_first_block),
      .csr_wr_en              (csr_wr_en),
      .csr_wr_data            (csr_wr_data),
      .init                   (init),
      .fifo_count             (fifo_count),
      .push                   (push),
      .push_item              (push_item)
   );

   p2ra_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .count      (fifo_count)
   );

   p2ra_back u_back (
      .clock            (clock),
      .reset            (reset),
      .init             (init),
      .head_valid       (head_valid),
      .head_item        (head_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_result_word  (rsp_result_word),
      .rsp_result_slot  (rsp_result_slot),
      .rsp_result_index (rsp_result_index)
   );

endmodule
